>>> hdl/utf8sd_pkg.sv
package utf8sd_pkg;

	localparam int CP_W     = 21;
	localparam int WIDTH_W  = 3;
	localparam int STATUS_W = 3;
	localparam int CNT_OUT_W = 16;

	// status codes
	localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
	localparam logic [STATUS_W-1:0] ST_STRAY    = 3'd1;
	localparam logic [STATUS_W-1:0] ST_BAD_LEAD = 3'd2;
	localparam logic [STATUS_W-1:0] ST_BAD_CONT = 3'd3;
	localparam logic [STATUS_W-1:0] ST_TRUNC    = 3'd4;

	// lead byte class boundaries
	localparam logic [7:0] ASCII_END = 8'h80;
	localparam logic [7:0] CONT_END  = 8'hC0;
	localparam logic [7:0] LEAD2_END = 8'hE0;
	localparam logic [7:0] LEAD3_END = 8'hF0;
	localparam logic [7:0] LEAD4_END = 8'hF8;

	// payload masks
	localparam logic [7:0] CONT_MASK  = 8'hC0;
	localparam logic [7:0] CONT_TAG   = 8'h80;
	localparam logic [7:0] CONT_BITS  = 8'h3F;
	localparam logic [7:0] LEAD2_BITS = 8'h1F;
	localparam logic [7:0] LEAD3_BITS = 8'h0F;
	localparam logic [7:0] LEAD4_BITS = 8'h07;

	typedef struct packed {
		logic [CP_W-1:0]      code_point;
		logic [WIDTH_W-1:0]   byte_width;
		logic [STATUS_W-1:0]  status;
		logic [CNT_OUT_W-1:0] char_count;
		logic                 last;
	} res_t;

endpackage

>>> hdl/utf8_stream_decoder.sv
// channel  dir  tdata                                        tuser        tlast
// s_axis   in   [7:0] byte_in                                -            end_of_string
// m_axis   out  [20:0] code_point, [23:21] byte_width,       [2:0] status last
//               [39:24] char_count
//
// One byte per cycle sustained while m_axis accepts; a byte is registered, decoded, and its result registered.
// Bytes that only extend a sequence produce no output transfer.
// arst_n clears the decoder state and the valid flags of both holding registers.
// A stalled m_axis holds its result; the input register still takes one
// more byte, and a byte that produces no result is consumed regardless.
module utf8_stream_decoder #(
	parameter int COUNT_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] byte_in
	input  logic        s_axis_tlast,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata,   // code_point, byte_width, char_count
	output logic [2:0]  m_axis_tuser,   // status
	output logic        m_axis_tlast
);
	import utf8sd_pkg::*;

	res_t res_c;
	res_t res_o;
	logic res_load;
	logic res_free;

	utf8sd_core #(.COUNT_BITS(COUNT_BITS)) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_byte  (s_axis_tdata),
		.in_eos   (s_axis_tlast),
		.res_free (res_free),
		.res_load (res_load),
		.res      (res_c)
	);

	utf8sd_out u_out (
		.clk     (clk),
		.arst_n  (arst_n),
		.load    (res_load),
		.res_in  (res_c),
		.free    (res_free),
		.vld     (m_axis_tvalid),
		.rdy     (m_axis_tready),
		.res_out (res_o)
	);

	assign m_axis_tdata = {res_o.char_count, res_o.byte_width, res_o.code_point};
	assign m_axis_tuser = res_o.status;
	assign m_axis_tlast = res_o.last;

endmodule

>>> hdl/utf8sd_core.sv
module utf8sd_core #(
	parameter int COUNT_BITS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [7:0]        in_byte,
	input  logic              in_eos,
	input  logic              res_free,
	output logic              res_load,
	output utf8sd_pkg::res_t  res
);
	import utf8sd_pkg::*;

	localparam int CW = (COUNT_BITS > CNT_OUT_W) ? COUNT_BITS : CNT_OUT_W;
	localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

	// input register
	logic       vld_s1;
	logic [7:0] byte_s1;
	logic       eos_s1;

	// decoder state
	logic [1:0]            pend_q;
	logic [CP_W-1:0]       part_q;
	logic [WIDTH_W-1:0]    wid_q;
	logic [COUNT_BITS-1:0] cnt_q;

	logic [1:0]            pend_n;
	logic [CP_W-1:0]       part_n;
	logic [WIDTH_W-1:0]    wid_n;
	logic [COUNT_BITS-1:0] cnt_n;
	logic                  emit;
	logic [STATUS_W-1:0]   st;
	logic [CP_W-1:0]       cp;
	logic [WIDTH_W-1:0]    w;
	logic [CW-1:0]         cnt_ext;
	logic                  consume;

	always_comb begin
		emit   = 1'b0;
		st     = ST_OK;
		cp     = '0;
		w      = '0;
		pend_n = pend_q;
		part_n = part_q;
		wid_n  = wid_q;
		cnt_n  = cnt_q;
		if (pend_q == 2'd0) begin
			if (byte_s1 < ASCII_END) begin
				emit = 1'b1;
				cp   = CP_W'(byte_s1);
				w    = WIDTH_W'(1);
			end else if (byte_s1 < CONT_END) begin
				emit = 1'b1;
				st   = ST_STRAY;
			end else if (byte_s1 < LEAD2_END) begin
				pend_n = 2'd1;
				part_n = CP_W'(byte_s1 & LEAD2_BITS);
				wid_n  = WIDTH_W'(2);
			end else if (byte_s1 < LEAD3_END) begin
				pend_n = 2'd2;
				part_n = CP_W'(byte_s1 & LEAD3_BITS);
				wid_n  = WIDTH_W'(3);
			end else if (byte_s1 < LEAD4_END) begin
				pend_n = 2'd3;
				part_n = CP_W'(byte_s1 & LEAD4_BITS);
				wid_n  = WIDTH_W'(4);
			end else begin
				emit = 1'b1;
				st   = ST_BAD_LEAD;
			end
		end else if ((byte_s1 & CONT_MASK) != CONT_TAG) begin
			// bad byte is dropped, not restarted as a lead
			emit   = 1'b1;
			st     = ST_BAD_CONT;
			pend_n = 2'd0;
			part_n = '0;
			wid_n  = '0;
		end else begin
			part_n = {part_q[CP_W-7:0], byte_s1[5:0]};
			pend_n = pend_q - 2'd1;
			if (pend_q == 2'd1) begin
				emit   = 1'b1;
				cp     = part_n;
				w      = wid_q;
				part_n = '0;
				wid_n  = '0;
			end
		end

		if (emit && st == ST_OK && cnt_q != CNT_MAX)
			cnt_n = cnt_q + 1'b1;

		if (!emit && eos_s1) begin
			emit = 1'b1;
			st   = ST_TRUNC;
		end

		cnt_ext = CW'(cnt_n);
	end

	assign res.code_point = cp;
	assign res.byte_width = w;
	assign res.status     = st;
	assign res.char_count = cnt_ext[CNT_OUT_W-1:0];
	assign res.last       = eos_s1;

	assign consume  = vld_s1 && (!emit || res_free);
	assign res_load = consume && emit;
	assign in_ready = !vld_s1 || consume;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_ready) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= in_byte;
			eos_s1  <= in_eos;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
			part_q <= '0;
			wid_q  <= '0;
			cnt_q  <= '0;
		end else if (consume) begin
			if (eos_s1) begin
				pend_q <= '0;
				part_q <= '0;
				wid_q  <= '0;
				cnt_q  <= '0;
			end else begin
				pend_q <= pend_n;
				part_q <= part_n;
				wid_q  <= wid_n;
				cnt_q  <= cnt_n;
			end
		end
	end

	// open sequence and recorded width always go together
	a_width_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(pend_q == 2'd0) == (wid_q == '0))
		else $error("width and pending count disagree");

	a_idle_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(pend_q == 2'd0) |-> (part_q == '0))
		else $error("partial code point left over while idle");

	a_eos_reset: assert property (@(posedge clk) disable iff (!arst_n)
		(consume && eos_s1) |=> (cnt_q == '0 && pend_q == 2'd0))
		else $error("state not cleared at string end");

	a_cnt_mono: assert property (@(posedge clk) disable iff (!arst_n)
		(consume && !eos_s1) |=> (cnt_q >= $past(cnt_q)))
		else $error("character count went backwards within a string");

endmodule

>>> hdl/utf8sd_out.sv
module utf8sd_out (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load,
	input  utf8sd_pkg::res_t res_in,
	output logic             free,
	output logic             vld,
	input  logic             rdy,
	output utf8sd_pkg::res_t res_out
);
	import utf8sd_pkg::*;

	logic vld_q;
	res_t res_q;

	assign free    = !vld_q || rdy;
	assign vld     = vld_q;
	assign res_out = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (load) begin
			vld_q <= 1'b1;
		end else if (rdy) begin
			vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load)
			res_q <= res_in;
	end

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_q && !rdy) |=> (vld_q && res_q == $past(res_q)))
		else $error("held result was overwritten");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> free)
		else $error("result loaded into a full register");

	a_status_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_q && res_q.status != ST_OK) |->
			(res_q.code_point == '0 && res_q.byte_width == '0))
		else $error("error result carries a code point");

endmodule

>>> verif/utf8_stream_decoder_test.sv
module utf8_stream_decoder_test;
	timeunit 1ns;
	timeprecision 1ps;

	import utf8sd_pkg::*;

	localparam int COUNT_BITS  = 16;
	localparam int CYCLE_LIMIT = 2_000_000;
	localparam int HOLD_LEN    = 300;
	localparam int DRAIN_WAIT  = 10;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = '0;
	logic        s_axis_tlast = 1'b0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [39:0] m_axis_tdata;
	logic [2:0]  m_axis_tuser;
	logic        m_axis_tlast;

	utf8_stream_decoder #(.COUNT_BITS(COUNT_BITS)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tlast(s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.m_axis_tlast(m_axis_tlast)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// decoder state as predicted
	logic [1:0]            seq_left;
	logic [CP_W-1:0]       seq_bits;
	logic [WIDTH_W-1:0]    seq_width;
	logic [COUNT_BITS-1:0] string_chars;

	res_t decoded_q[$];
	res_t due;

	int mismatches = 0;
	int bytes_sent = 0;
	int chars_checked = 0;
	int faults_checked = 0;
	int cycle_count;

	bit send_idle = 1'b0;
	bit recv_idle = 1'b0;
	bit hold_token = 1'b0;
	bit hold_seen = 1'b0;
	int hold_left = 0;

	task automatic report(input string what, input logic [39:0] got, input logic [39:0] want);
		mismatches++;
		$display("%0t mismatch %s: got %0h, want %0h", $realtime, what, got, want);
	endtask

	// next decoder state plus the result this byte yields, if any
	task automatic decode_byte(input logic [7:0] b, input logic eos);
		res_t r;
		bit emit;
		emit = 1'b0;
		r = '0;
		r.status = ST_OK;
		if (seq_left == 2'd0) begin
			if (b < ASCII_END) begin
				emit = 1'b1;
				r.code_point = CP_W'(b);
				r.byte_width = 3'd1;
			end else if (b < CONT_END) begin
				emit = 1'b1;
				r.status = ST_STRAY;
			end else if (b < LEAD2_END) begin
				seq_left = 2'd1;
				seq_bits = CP_W'(b & LEAD2_BITS);
				seq_width = 3'd2;
			end else if (b < LEAD3_END) begin
				seq_left = 2'd2;
				seq_bits = CP_W'(b & LEAD3_BITS);
				seq_width = 3'd3;
			end else if (b < LEAD4_END) begin
				seq_left = 2'd3;
				seq_bits = CP_W'(b & LEAD4_BITS);
				seq_width = 3'd4;
			end else begin
				emit = 1'b1;
				r.status = ST_BAD_LEAD;
			end
		end else if ((b & CONT_MASK) != CONT_TAG) begin
			// offending byte is dropped, not reinterpreted as a lead
			emit = 1'b1;
			r.status = ST_BAD_CONT;
			seq_left = 2'd0;
			seq_bits = '0;
			seq_width = '0;
		end else begin
			seq_bits = {seq_bits[CP_W-7:0], b[5:0]};
			seq_left = seq_left - 2'd1;
			if (seq_left == 2'd0) begin
				emit = 1'b1;
				r.code_point = seq_bits;
				r.byte_width = seq_width;
				seq_bits = '0;
				seq_width = '0;
			end
		end
		if (emit && r.status == ST_OK && string_chars != '1)
			string_chars = string_chars + 1'b1;
		if (!emit && eos) begin
			emit = 1'b1;
			r.status = ST_TRUNC;
		end
		if (emit) begin
			r.char_count = CNT_OUT_W'(string_chars);
			r.last = eos;
			decoded_q.push_back(r);
		end
		if (eos) begin
			seq_left = '0;
			seq_bits = '0;
			seq_width = '0;
			string_chars = '0;
		end
	endtask

	task automatic send_byte(input logic [7:0] b, input logic eos);
		if (send_idle && $urandom_range(99) < 10) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= b;
		s_axis_tlast <= eos;
		do @(posedge clk); while (!s_axis_tready);
		bytes_sent++;
		decode_byte(b, eos);
	endtask

	// mostly well-formed text; some bytes corrupted, some strings cut mid-character
	task automatic send_random_string(input int max_chars);
		logic [7:0] text[$];
		int nch, w, i, k;
		nch = $urandom_range(1, max_chars);
		w = 1;
		for (i = 0; i < nch; i++) begin
			w = $urandom_range(1, 4);
			case (w)
				1: text.push_back({1'b0, 7'($urandom)});
				2: text.push_back({3'b110, 5'($urandom)});
				3: text.push_back({4'b1110, 4'($urandom)});
				default: text.push_back({5'b11110, 3'($urandom)});
			endcase
			for (k = 1; k < w; k++)
				text.push_back({2'b10, 6'($urandom)});
			if ($urandom_range(99) < 8)
				text[$urandom_range(text.size() - w, text.size() - 1)] = 8'($urandom);
		end
		if (w > 1 && $urandom_range(99) < 15)
			repeat ($urandom_range(1, w - 1)) void'(text.pop_back());
		for (i = 0; i < text.size(); i++)
			send_byte(text[i], i == text.size() - 1);
	endtask

	task automatic test_directed();
		logic [8:0] seq[] = '{
			9'h000, 9'h17F,              // lowest and highest ASCII
			9'h041, 9'h080, 9'h1BF,      // ASCII, then stray continuations, one closing the string
			9'h0C0, 9'h180,              // overlong two-byte NUL
			9'h0DF, 9'h0BF,
			9'h0ED, 9'h0A0, 9'h180,      // surrogate passes through
			9'h0F7, 9'h0BF, 9'h0BF, 9'h0BF, // largest four-byte payload
			9'h0F8, 9'h1FF,              // bad leads
			9'h0C3, 9'h041, 9'h07A,      // bad continuation, byte dropped
			9'h0E2, 9'h182,              // truncated mid-sequence
			9'h1F0                       // truncated on the lead itself
		};
		foreach (seq[i])
			send_byte(seq[i][7:0], seq[i][8]);
	endtask

	task automatic test_random_strings(input int n_bytes, input bit idle);
		int stop_at;
		send_idle = idle;
		recv_idle <= idle;
		stop_at = bytes_sent + n_bytes;
		while (bytes_sent < stop_at)
			send_random_string(12);
	endtask

	task automatic test_backpressure();
		send_idle = 1'b0;
		hold_token <= ~hold_token;
		repeat (40) send_random_string(4);
	endtask

	// count carries well past the low byte within one string
	task automatic test_long_string();
		send_idle = 1'b0;
		recv_idle <= 1'b0;
		repeat (300) send_byte(8'($urandom_range(0, 127)), 1'b0);
		send_byte(8'h21, 1'b1);
	endtask

	// receiver: random stalls, or a long hold-off when requested
	always @(posedge clk) begin
		if (hold_token != hold_seen) begin
			hold_seen <= hold_token;
			hold_left <= HOLD_LEN;
			m_axis_tready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			m_axis_tready <= 1'b0;
		end else if (recv_idle) begin
			m_axis_tready <= ($urandom_range(99) >= 10);
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (decoded_q.size() == 0) begin
				report("transfer with nothing pending", m_axis_tdata, '0);
			end else begin
				due = decoded_q.pop_front();
				if (m_axis_tdata[20:0] != due.code_point)
					report("code_point", 40'(m_axis_tdata[20:0]), 40'(due.code_point));
				if (m_axis_tdata[23:21] != due.byte_width)
					report("byte_width", 40'(m_axis_tdata[23:21]), 40'(due.byte_width));
				if (m_axis_tdata[39:24] != due.char_count)
					report("char_count", 40'(m_axis_tdata[39:24]), 40'(due.char_count));
				if (m_axis_tuser != due.status)
					report("status", 40'(m_axis_tuser), 40'(due.status));
				if (m_axis_tlast != due.last)
					report("last", 40'(m_axis_tlast), 40'(due.last));
				if (due.status == ST_OK)
					chars_checked++;
				else
					faults_checked++;
			end
		end
	end

	initial begin
		for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++)
			@(posedge clk);
		$display("CHECK FAILED");
		$finish;
	end

	initial begin
		seq_left = '0;
		seq_bits = '0;
		seq_width = '0;
		string_chars = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		recv_idle <= 1'b1;
		@(posedge clk);

		send_idle = 1'b1;
		test_directed();
		test_random_strings(300, 1'b0);
		test_random_strings(750, 1'b1);
		test_backpressure();
		test_long_string();
		s_axis_tvalid <= 1'b0;

		wait (decoded_q.size() == 0);
		repeat (DRAIN_WAIT) @(posedge clk);

		$display("decoded %0d bytes: %0d characters and %0d error results compared",
			bytes_sent, chars_checked, faults_checked);
		$display("covered all lead classes, bad/truncated sequences, a long output stall, "
			, "and a string long enough to carry the character count past one byte");
		if (mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

>>> utf8_stream_decoder.f
hdl/utf8sd_pkg.sv
hdl/utf8sd_core.sv
hdl/utf8sd_out.sv
hdl/utf8_stream_decoder.sv
verif/utf8_stream_decoder_test.sv
